@@ design/sscs_pkg.sv @@
package sscs_pkg;

    localparam int FRAME_W = 32;

    typedef enum logic [1:0] {
        KIND_TIME   = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_FLASH  = 2'd3
    } t_kind;

    // Request fields that ride along the pipeline untouched.
    typedef struct packed {
        t_kind       kind;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [3:0]  err_code;
    } t_req;

    typedef struct packed {
        t_req        req;
        logic [15:0] number;
    } t_s0;

    typedef struct packed {
        t_req        req;
        logic [15:0] number;
        logic [2:0]  q10k;
    } t_s1;

    typedef struct packed {
        t_req        req;
        logic [13:0] low4;
        logic [6:0]  hi_pair;
    } t_s2;

    typedef struct packed {
        t_req        req;
        logic [6:0]  hi_pair;
        logic [6:0]  lo_pair;
    } t_s3;

endpackage

@@ design/seven_segment_clock_serializer_core.sv @@
// Serializer for a four-digit seven-segment display behind a shift register.
// Slave stream: one request per item; tuser carries the request kind (time,
// number, error, flash) and tdata the hour, minute, number and error code.
// Master stream: 32 items per frame, one shift-data bit each in tdata bit 0,
// with tlast on the final bit where the latch pulse belongs. A time request
// that arrives after a flash request (or error code 1) yields no frame.
// The cfg channel holds the common-cathode bit, which inverts every frame bit.
// A request passes through the input register, three decimal-split stages,
// the frame buffer and the shifter. The shifter sends one bit per cycle while
// the receiver holds tready high; a built frame waits in the frame buffer and
// the pipeline holds up to four more requests, so frames leave without gaps.
// Reset clears all valid flags, the flash flag and the common-cathode bit.
// When the receiver drops tready, the current bit holds and the stages fill
// up behind it until the slave-side tready goes low.
module seven_segment_clock_serializer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // hour[4:0], minute[10:5], number[26:11], err_code[30:27]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // serial_bit[0]
    output logic        o_m_tlast
);
    import sscs_pkg::*;

    localparam logic [3:0] ERR_FLASH = 4'd1;
    localparam int         CNT_W     = $clog2(FRAME_W);

    function automatic logic [15:0] ten_k(input logic [2:0] q);
        logic [15:0] v;
        case (q)
            3'd1:    v = 16'd10000;
            3'd2:    v = 16'd20000;
            3'd3:    v = 16'd30000;
            3'd4:    v = 16'd40000;
            3'd5:    v = 16'd50000;
            3'd6:    v = 16'd60000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    t_s0 r_s0;
    t_s1 r_s1;
    t_s2 r_s2;
    t_s3 r_s3;
    logic r_v0, r_v1, r_v2, r_v3;
    logic [FRAME_W-1:0] r_frm;
    logic               r_frm_vld;
    logic [FRAME_W-1:0] r_sh;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sh_vld;
    logic               r_flash;
    logic               r_cc;

    logic               in_acc, out_acc, last_bit, sh_load;
    logic               adv0, adv1, adv2, adv3;
    logic               drop, sets_flash;
    logic [32:0]        q_prod;
    logic [15:0]        low4_full;
    logic [26:0]        hp_prod;
    logic [13:0]        hp100;
    logic [13:0]        lp_full;
    logic [FRAME_W-1:0] frame;

    assign o_cfg_ready = 1'b1;

    assign out_acc  = r_sh_vld && i_m_tready;
    assign last_bit = (r_cnt == CNT_W'(FRAME_W - 1));
    assign sh_load  = r_frm_vld && (!r_sh_vld || (out_acc && last_bit));
    assign adv3     = r_v3 && (!r_frm_vld || sh_load);
    assign adv2     = r_v2 && (!r_v3 || adv3);
    assign adv1     = r_v1 && (!r_v2 || adv2);
    assign adv0     = r_v0 && (!r_v1 || adv1);
    assign o_s_tready = !r_v0 || adv0;
    assign in_acc   = i_s_tvalid && o_s_tready;

    assign drop       = (r_s3.req.kind == KIND_TIME) && r_flash;
    assign sets_flash = (r_s3.req.kind == KIND_FLASH) ||
                        ((r_s3.req.kind == KIND_ERROR) && (r_s3.req.err_code == ERR_FLASH));

    // Low four decimal digits: v / 10000 by reciprocal, then split into pairs.
    assign q_prod    = 33'(r_s0.number) * 33'd107375;
    assign low4_full = r_s1.number - ten_k(r_s1.q10k);
    assign hp_prod   = 27'(low4_full[13:0]) * 27'd5243;
    assign hp100     = 14'({r_s2.hi_pair, 6'b0}) + 14'({r_s2.hi_pair, 5'b0}) +
                       14'({r_s2.hi_pair, 2'b0});
    assign lp_full   = r_s2.low4 - hp100;

    sscs_frame u_frame (
        .i_s3    (r_s3),
        .i_cc    (r_cc),
        .o_frame (frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_frm_vld <= 1'b0;
            r_sh_vld  <= 1'b0;
            r_cnt     <= '0;
            r_flash   <= 1'b0;
            r_cc      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cc <= i_cfg_data;
            end
            if (in_acc) begin
                r_v0 <= 1'b1;
            end else if (adv0) begin
                r_v0 <= 1'b0;
            end
            if (adv0) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (adv3) begin
                r_v3 <= 1'b0;
            end
            if (adv3 && !drop) begin
                r_frm_vld <= 1'b1;
            end else if (sh_load) begin
                r_frm_vld <= 1'b0;
            end
            if (adv3 && sets_flash) begin
                r_flash <= 1'b1;
            end
            if (sh_load) begin
                r_sh_vld <= 1'b1;
                r_cnt    <= '0;
            end else if (out_acc) begin
                if (last_bit) begin
                    r_sh_vld <= 1'b0;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0.req.kind     <= t_kind'(i_s_tuser);
            r_s0.req.hour     <= i_s_tdata[4:0];
            r_s0.req.minute   <= i_s_tdata[10:5];
            r_s0.number       <= i_s_tdata[26:11];
            r_s0.req.err_code <= i_s_tdata[30:27];
        end
        if (adv0) begin
            r_s1.req    <= r_s0.req;
            r_s1.number <= r_s0.number;
            r_s1.q10k   <= q_prod[32:30];
        end
        if (adv1) begin
            r_s2.req     <= r_s1.req;
            r_s2.low4    <= low4_full[13:0];
            r_s2.hi_pair <= hp_prod[25:19];
        end
        if (adv2) begin
            r_s3.req     <= r_s2.req;
            r_s3.hi_pair <= r_s2.hi_pair;
            r_s3.lo_pair <= lp_full[6:0];
        end
        if (adv3 && !drop) begin
            r_frm <= frame;
        end
        if (sh_load) begin
            r_sh <= r_frm;
        end else if (out_acc) begin
            r_sh <= {1'b0, r_sh[FRAME_W-1:1]};
        end
    end

    assign o_m_tvalid = r_sh_vld;
    assign o_m_tdata  = {7'b0, r_sh[0]};
    assign o_m_tlast  = last_bit;

    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && last_bit && r_frm_vld) |=> (r_sh_vld && (r_cnt == '0)))
        else $error("pending frame not loaded after last bit");

    a_flash_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flash |=> r_flash)
        else $error("flash flag cleared without reset");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !last_bit) |=> (r_sh_vld && (r_cnt == $past(r_cnt) + CNT_W'(1))))
        else $error("bit counter did not advance by one");

    a_no_drop_into_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && drop && !sh_load) |=> (r_frm_vld == $past(r_frm_vld)))
        else $error("suppressed time request changed the frame buffer");

endmodule

@@ design/sscs_frame.sv @@
module sscs_frame (
    input  sscs_pkg::t_s3                i_s3,
    input  logic                         i_cc,
    output logic [sscs_pkg::FRAME_W-1:0] o_frame
);
    import sscs_pkg::*;

    localparam logic [4:0] GLYPH_E     = 5'd10;
    localparam logic [4:0] GLYPH_F     = 5'd11;
    localparam logic [4:0] GLYPH_H     = 5'd12;
    localparam logic [4:0] GLYPH_L     = 5'd13;
    localparam logic [4:0] GLYPH_R     = 5'd14;
    localparam logic [4:0] GLYPH_S     = 5'd15;
    localparam logic [4:0] GLYPH_BLANK = 5'd16;

    // Segment levels for a common-anode display, segment a in bit 6 and g in bit 0.
    function automatic logic [6:0] seg_bits(input logic [4:0] sym);
        logic [6:0] s;
        case (sym)
            5'd0:    s = 7'h01;
            5'd1:    s = 7'h4F;
            5'd2:    s = 7'h12;
            5'd3:    s = 7'h06;
            5'd4:    s = 7'h4C;
            5'd5:    s = 7'h24;
            5'd6:    s = 7'h20;
            5'd7:    s = 7'h0F;
            5'd8:    s = 7'h00;
            5'd9:    s = 7'h0C;
            GLYPH_E: s = 7'h30;
            GLYPH_F: s = 7'h38;
            GLYPH_H: s = 7'h48;
            GLYPH_L: s = 7'h71;
            GLYPH_R: s = 7'h19;
            GLYPH_S: s = 7'h24;
            default: s = 7'h7F;
        endcase
        return s;
    endfunction

    // Tens and ones of a value below 128; x*205 >> 11 is exact in that range.
    function automatic logic [7:0] split10(input logic [6:0] x);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  tx10;
        logic [6:0]  ones;
        p    = 15'(x) * 15'd205;
        t    = p[14:11];
        tx10 = 7'({t, 3'b000}) + 7'({t, 1'b0});
        ones = x - tx10;
        return {t, ones[3:0]};
    endfunction

    function automatic logic [7:0] char_bits(input logic [4:0] sym, input logic dp,
                                             input logic cc);
        return {~dp, seg_bits(sym)} ^ {8{cc}};
    endfunction

    logic [4:0] h12;
    logic       pm;
    logic [7:0] hour_split;
    logic [7:0] min_split;
    logic [7:0] lo_split;
    logic [7:0] hi_split;
    logic [4:0] ht_sym;
    logic [4:0] sym [4];
    logic       dp  [4];

    always_comb begin
        pm = (i_s3.req.hour >= 5'd12);
        if (i_s3.req.hour == 5'd0) begin
            h12 = 5'd12;
        end else if (i_s3.req.hour > 5'd12) begin
            h12 = i_s3.req.hour - 5'd12;
        end else begin
            h12 = i_s3.req.hour;
        end
    end

    assign hour_split = split10({2'b00, h12});
    assign min_split  = split10({1'b0, i_s3.req.minute});
    assign lo_split   = split10(i_s3.lo_pair);
    assign hi_split   = split10(i_s3.hi_pair);
    assign ht_sym     = (hour_split[7:4] == 4'd0) ? GLYPH_BLANK : {1'b0, hour_split[7:4]};

    // The rightmost character of the display is sent first.
    always_comb begin
        dp[0] = 1'b0;
        dp[1] = 1'b0;
        dp[2] = 1'b0;
        dp[3] = 1'b0;
        unique case (i_s3.req.kind)
            KIND_TIME: begin
                sym[0] = {1'b0, min_split[3:0]};
                sym[1] = {1'b0, min_split[7:4]};
                sym[2] = {1'b0, hour_split[3:0]};
                sym[3] = ht_sym;
                dp[0]  = pm;
                dp[2]  = 1'b1;
            end
            KIND_NUMBER: begin
                sym[0] = {1'b0, lo_split[3:0]};
                sym[1] = {1'b0, lo_split[7:4]};
                sym[2] = {1'b0, hi_split[3:0]};
                sym[3] = {1'b0, hi_split[7:4]};
            end
            KIND_ERROR: begin
                sym[0] = {1'b0, i_s3.req.err_code};
                sym[1] = GLYPH_R;
                sym[2] = GLYPH_R;
                sym[3] = GLYPH_E;
            end
            KIND_FLASH: begin
                sym[0] = GLYPH_H;
                sym[1] = GLYPH_S;
                sym[2] = GLYPH_L;
                sym[3] = GLYPH_F;
            end
            default: begin
                sym[0] = GLYPH_BLANK;
                sym[1] = GLYPH_BLANK;
                sym[2] = GLYPH_BLANK;
                sym[3] = GLYPH_BLANK;
            end
        endcase
    end

    assign o_frame = {char_bits(sym[3], dp[3], i_cc), char_bits(sym[2], dp[2], i_cc),
                      char_bits(sym[1], dp[1], i_cc), char_bits(sym[0], dp[0], i_cc)};

endmodule
